// ===== hdl/tcte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcte_pkg
// Shared constants, codes and controller/datapath signal groups for the text
// cursor terminal engine.
// ----------------------------------------------------------------------------
package tcte_pkg;

    // Screen geometry in pixels
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 320;

    // Field widths
    localparam int CURSOR_W = 16;
    localparam int DIM_W    = 7;
    localparam int CODE_W   = 8;
    localparam int POS_W    = 10;
    localparam int KIND_W   = 2;
    localparam int SCROLL_W = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Stream packing
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    // Results kept per input item
    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = 3;

    // Tab padding puts at most this many spaces
    localparam int TAB_LIMIT = 3;

    // Divider steps, one quotient bit each
    localparam int DIV_STEPS  = CURSOR_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    // Operation codes
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_SET = 1'b1;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd2;

    // Character codes
    localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
    localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT  = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic set_cursor;
        logic clear_x;
        logic lf_step1;
        logic lf_step2;
        logic bs_step1;
        logic bs_step2;
        logic print;
        logic div_start;
        logic finish;
        logic sel_space;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_set;
        logic is_bs;
        logic is_cr;
        logic is_lf;
        logic is_tab;
        logic wrap_needed;
        logic out_free;
        logic width_zero;
        logic div_done;
        logic div_odd;
    } t_stat;

endpackage

// ===== hdl/tcte_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcte_div
// Restoring divider, one quotient bit per cycle. Reports only the parity of
// the quotient of an unsigned cursor magnitude by the glyph width.
// ----------------------------------------------------------------------------
module tcte_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tcte_pkg::CURSOR_W-1:0] i_dividend,
    input  logic [tcte_pkg::DIM_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic                          o_odd
);

    logic                            r_busy;
    logic [tcte_pkg::DIV_STEP_W-1:0] r_step;
    logic [tcte_pkg::CURSOR_W-1:0]   r_num;
    logic [tcte_pkg::DIM_W-1:0]      r_den;
    logic [tcte_pkg::DIM_W-1:0]      r_rem;
    logic                            r_done;
    logic                            r_odd;

    logic [tcte_pkg::DIM_W:0] rem_sh;
    logic [tcte_pkg::DIM_W:0] rem_diff;
    logic                     q_bit;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        rem_sh   = {r_rem, r_num[tcte_pkg::CURSOR_W-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        q_bit    = (rem_sh >= {1'b0, r_den});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == tcte_pkg::DIV_STEP_W'(tcte_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[tcte_pkg::CURSOR_W-2:0], 1'b0};
            r_rem <= q_bit ? rem_diff[tcte_pkg::DIM_W-1:0] : rem_sh[tcte_pkg::DIM_W-1:0];
            r_odd <= q_bit;
        end
    end

    assign o_done = r_done;
    assign o_odd  = r_odd;

endmodule

// ===== hdl/tcte_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcte_datapath
// Cursor and configuration registers, cursor arithmetic, pending result and
// output register, and the tab parity divider.
// ----------------------------------------------------------------------------
module tcte_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input beat fields
    input  logic                            i_operation,
    input  logic [tcte_pkg::CODE_W-1:0]     i_char_code,
    input  logic [tcte_pkg::POS_W-1:0]      i_new_x,
    input  logic [tcte_pkg::POS_W-1:0]      i_new_y,
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [tcte_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcte_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Controller link
    input  tcte_pkg::t_cmd                  i_cmd,
    output tcte_pkg::t_stat                 o_stat,
    // Result register
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [tcte_pkg::KIND_W-1:0]     o_kind,
    output logic [tcte_pkg::CURSOR_W-1:0]   o_cell_x,
    output logic [tcte_pkg::CURSOR_W-1:0]   o_cell_y,
    output logic [tcte_pkg::CODE_W-1:0]     o_glyph_index,
    output logic [tcte_pkg::SCROLL_W-1:0]   o_scroll_lines,
    output logic                            o_last
);

    localparam logic signed [17:0] SW_S = 18'(tcte_pkg::SCREEN_WIDTH);
    localparam logic signed [17:0] SH_S = 18'(tcte_pkg::SCREEN_HEIGHT);

    // Configuration
    logic [tcte_pkg::DIM_W-1:0]  r_gw;
    logic [tcte_pkg::DIM_W-1:0]  r_gh;
    logic [tcte_pkg::CODE_W-1:0] r_first;
    logic [tcte_pkg::CODE_W-1:0] r_count;
    logic                        r_transp;

    // Cursor and latched item
    logic [tcte_pkg::CURSOR_W-1:0] r_cx;
    logic [tcte_pkg::CURSOR_W-1:0] r_cy;
    logic                          r_op;
    logic [tcte_pkg::CODE_W-1:0]   r_char;
    logic [tcte_pkg::POS_W-1:0]    r_nx;
    logic [tcte_pkg::POS_W-1:0]    r_ny;

    // Result count for this item
    logic [tcte_pkg::RES_CNT_W-1:0] r_ecnt;

    // Pending result
    logic                          r_pend_valid;
    logic [tcte_pkg::KIND_W-1:0]   r_pend_kind;
    logic [tcte_pkg::CURSOR_W-1:0] r_pend_x;
    logic [tcte_pkg::CURSOR_W-1:0] r_pend_y;
    logic [tcte_pkg::CODE_W-1:0]   r_pend_g;
    logic [tcte_pkg::SCROLL_W-1:0] r_pend_s;

    // Output register
    logic                          r_out_valid;
    logic [tcte_pkg::KIND_W-1:0]   r_out_kind;
    logic [tcte_pkg::CURSOR_W-1:0] r_out_x;
    logic [tcte_pkg::CURSOR_W-1:0] r_out_y;
    logic [tcte_pkg::CODE_W-1:0]   r_out_g;
    logic [tcte_pkg::SCROLL_W-1:0] r_out_s;
    logic                          r_out_last;

    // Combinational helpers
    logic [tcte_pkg::CODE_W-1:0]   pc;
    logic                          in_font;
    logic signed [17:0]            x_plus_w;
    logic signed [17:0]            lf_d;
    logic [tcte_pkg::CURSOR_W-1:0] cy_dec;
    logic [tcte_pkg::CURSOR_W-1:0] cx_abs;
    logic                          emit_req;
    logic [tcte_pkg::KIND_W-1:0]   emit_kind;
    logic [tcte_pkg::CODE_W-1:0]   emit_g;
    logic [tcte_pkg::SCROLL_W-1:0] emit_s;
    logic                          emit_pos;
    logic                          push;
    logic                          load_out;
    logic                          div_done;
    logic                          div_odd;

    // Font lookup and wrap checks
    always_comb begin
        pc       = i_cmd.sel_space ? tcte_pkg::CH_SPACE : r_char;
        in_font  = ({1'b0, pc} >= {1'b0, r_first}) &&
                   ({1'b0, pc} < ({1'b0, r_first} + {1'b0, r_count}));
        x_plus_w = {{2{r_cx[tcte_pkg::CURSOR_W-1]}}, r_cx} + {11'b0, r_gw};
        lf_d     = {{2{r_cy[tcte_pkg::CURSOR_W-1]}}, r_cy} + {11'b0, r_gh} - SH_S;
        cy_dec   = r_cy - {9'b0, r_gh};
        cx_abs   = r_cx[tcte_pkg::CURSOR_W-1] ? (~r_cx + 1'b1) : r_cx;
    end

    // Build the result that the current step emits
    always_comb begin
        emit_req  = 1'b0;
        emit_kind = tcte_pkg::KIND_DRAW;
        emit_g    = '0;
        emit_s    = '0;
        emit_pos  = 1'b0;
        if (i_cmd.lf_step2) begin
            emit_req  = !lf_d[17] && (lf_d != '0);
            emit_kind = tcte_pkg::KIND_SCROLL;
            emit_s    = lf_d[tcte_pkg::SCROLL_W-1:0];
        end else if (i_cmd.print) begin
            emit_pos = 1'b1;
            if (in_font) begin
                emit_req  = 1'b1;
                emit_kind = tcte_pkg::KIND_DRAW;
                emit_g    = pc - r_first;
            end else begin
                emit_req  = !r_transp;
                emit_kind = tcte_pkg::KIND_FILL;
            end
        end
    end

    // Drop results past the limit
    assign push     = emit_req && (r_ecnt < tcte_pkg::RES_CNT_W'(tcte_pkg::MAX_RESULTS));
    assign load_out = (push || i_cmd.finish) && r_pend_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw     <= 7'd8;
            r_gh     <= 7'd8;
            r_first  <= 8'd32;
            r_count  <= 8'd95;
            r_transp <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcte_pkg::CFG_GLYPH_WIDTH:  r_gw     <= i_cfg_data[tcte_pkg::DIM_W-1:0];
                tcte_pkg::CFG_GLYPH_HEIGHT: r_gh     <= i_cfg_data[tcte_pkg::DIM_W-1:0];
                tcte_pkg::CFG_FIRST_CODE:   r_first  <= i_cfg_data;
                tcte_pkg::CFG_CODE_COUNT:   r_count  <= i_cfg_data;
                tcte_pkg::CFG_TRANSPARENT:  r_transp <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_operation;
            r_char <= i_char_code;
            r_nx   <= i_new_x;
            r_ny   <= i_new_y;
        end
    end

    // Cursor updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cmd.set_cursor) begin
            r_cx <= {6'b0, r_nx};
            r_cy <= {6'b0, r_ny};
        end else if (i_cmd.clear_x) begin
            r_cx <= '0;
        end else if (i_cmd.lf_step1) begin
            r_cx <= '0;
            r_cy <= r_cy + {9'b0, r_gh};
        end else if (i_cmd.lf_step2) begin
            if (!lf_d[17]) begin
                r_cy <= tcte_pkg::CURSOR_W'(tcte_pkg::SCREEN_HEIGHT) - {9'b0, r_gh};
            end
        end else if (i_cmd.bs_step1) begin
            r_cx <= r_cx - {9'b0, r_gw};
        end else if (i_cmd.bs_step2) begin
            if (r_cx[tcte_pkg::CURSOR_W-1]) begin
                r_cy <= cy_dec[tcte_pkg::CURSOR_W-1] ? '0 : cy_dec;
                r_cx <= r_cx + tcte_pkg::CURSOR_W'(tcte_pkg::SCREEN_WIDTH);
            end
        end else if (i_cmd.print) begin
            r_cx <= r_cx + {9'b0, r_gw};
        end
    end

    // Pending result and result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_ecnt       <= '0;
        end else if (i_cmd.load_item) begin
            r_pend_valid <= 1'b0;
            r_ecnt       <= '0;
        end else if (push) begin
            r_pend_valid <= 1'b1;
            r_ecnt       <= r_ecnt + 1'b1;
        end else if (i_cmd.finish) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_pend_kind <= emit_kind;
            r_pend_x    <= emit_pos ? r_cx : '0;
            r_pend_y    <= emit_pos ? r_cy : '0;
            r_pend_g    <= emit_g;
            r_pend_s    <= emit_s;
        end
    end

    // Output register: load from pending, drop on downstream take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_kind <= r_pend_kind;
            r_out_x    <= r_pend_x;
            r_out_y    <= r_pend_y;
            r_out_g    <= r_pend_g;
            r_out_s    <= r_pend_s;
            r_out_last <= i_cmd.finish;
        end
    end

    // Tab parity divider
    tcte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (cx_abs),
        .i_divisor  (r_gw),
        .o_done     (div_done),
        .o_odd      (div_odd)
    );

    // Status back to the controller
    always_comb begin
        o_stat.is_set      = (r_op == tcte_pkg::OP_SET);
        o_stat.is_bs       = (r_char == tcte_pkg::CH_BS);
        o_stat.is_cr       = (r_char == tcte_pkg::CH_CR);
        o_stat.is_lf       = (r_char == tcte_pkg::CH_LF);
        o_stat.is_tab      = (r_char == tcte_pkg::CH_TAB);
        o_stat.wrap_needed = in_font && (x_plus_w > SW_S);
        o_stat.out_free    = !r_out_valid || i_out_ready;
        o_stat.width_zero  = (r_gw == '0);
        o_stat.div_done    = div_done;
        o_stat.div_odd     = div_odd;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_cell_x       = r_out_x;
    assign o_cell_y       = r_out_y;
    assign o_glyph_index  = r_out_g;
    assign o_scroll_lines = r_out_s;
    assign o_last         = r_out_last;

endmodule

// ===== hdl/tcte_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcte_ctrl
// Sequencer that walks one input item through cursor set, auto wrap,
// control-code handling, tab padding and result flush, one step per state.
// ----------------------------------------------------------------------------
module tcte_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tcte_pkg::t_stat i_stat,
    output tcte_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_MAIN  = 4'd2;
    localparam logic [3:0] ST_LF1   = 4'd3;
    localparam logic [3:0] ST_LF2   = 4'd4;
    localparam logic [3:0] ST_BS1   = 4'd5;
    localparam logic [3:0] ST_BS2   = 4'd6;
    localparam logic [3:0] ST_TWRAP = 4'd7;
    localparam logic [3:0] ST_PRINT = 4'd8;
    localparam logic [3:0] ST_TCHK  = 4'd9;
    localparam logic [3:0] ST_DIV   = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    // Where a line feed returns to
    localparam logic [1:0] RET_MAIN  = 2'd0;
    localparam logic [1:0] RET_PRINT = 2'd1;
    localparam logic [1:0] RET_FIN   = 2'd2;

    localparam logic [1:0] TAB_LAST = 2'(tcte_pkg::TAB_LIMIT - 1);

    logic [3:0] r_state, n_state;
    logic [1:0] r_ret, n_ret;
    logic       r_tab, n_tab;
    logic [1:0] r_tab_cnt, n_tab_cnt;

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_tab     = r_tab;
        n_tab_cnt = r_tab_cnt;
        o_cmd     = '0;
        o_cmd.sel_space = r_tab;
        o_in_ready = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_tab   = 1'b0;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_stat.is_set) begin
                    o_cmd.set_cursor = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_stat.wrap_needed) begin
                    n_ret   = RET_MAIN;
                    n_state = ST_LF1;
                end else begin
                    n_state = ST_MAIN;
                end
            end
            ST_MAIN: begin
                priority if (i_stat.is_bs) begin
                    n_state = ST_BS1;
                end else if (i_stat.is_cr) begin
                    o_cmd.clear_x = 1'b1;
                    n_state = ST_FIN;
                end else if (i_stat.is_lf) begin
                    n_ret   = RET_FIN;
                    n_state = ST_LF1;
                end else if (i_stat.is_tab) begin
                    n_tab     = 1'b1;
                    n_tab_cnt = '0;
                    n_state   = ST_TWRAP;
                end else begin
                    n_state = ST_PRINT;
                end
            end
            ST_LF1: begin
                o_cmd.lf_step1 = 1'b1;
                n_state = ST_LF2;
            end
            ST_LF2: begin
                // Hold until a possible scroll result has room
                if (i_stat.out_free) begin
                    o_cmd.lf_step2 = 1'b1;
                    unique case (r_ret)
                        RET_MAIN:  n_state = ST_MAIN;
                        RET_PRINT: n_state = ST_PRINT;
                        default:   n_state = ST_FIN;
                    endcase
                end
            end
            ST_BS1: begin
                o_cmd.bs_step1 = 1'b1;
                n_state = ST_BS2;
            end
            ST_BS2: begin
                o_cmd.bs_step2 = 1'b1;
                n_state = ST_FIN;
            end
            ST_TWRAP: begin
                if (i_stat.wrap_needed) begin
                    n_ret   = RET_PRINT;
                    n_state = ST_LF1;
                end else begin
                    n_state = ST_PRINT;
                end
            end
            ST_PRINT: begin
                if (i_stat.out_free) begin
                    o_cmd.print = 1'b1;
                    n_state = r_tab ? ST_TCHK : ST_FIN;
                end
            end
            ST_TCHK: begin
                if (i_stat.width_zero || (r_tab_cnt == TAB_LAST)) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.div_odd) begin
                        n_tab_cnt = r_tab_cnt + 1'b1;
                        n_state   = ST_TWRAP;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // Flush the held result with the last flag
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ret     <= RET_MAIN;
            r_tab     <= 1'b0;
            r_tab_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_tab     <= n_tab;
            r_tab_cnt <= n_tab_cnt;
        end
    end

endmodule

// ===== hdl/text_cursor_terminal_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cursor_terminal_engine
// Cursor control for a cell-based text screen: turns character bytes and
// cursor-set requests into glyph-draw, cell-fill and scroll-up commands.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser: operation
//                                                       tdata: char, new_x, new_y
//  m_axis    out        m_axis_tvalid / m_axis_tready   tuser: command_kind
//                                                       tdata: x, y, glyph, scroll
//                                                       tlast: last of item
//  cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
//  One item at a time: a new input beat is taken only once the last one is
//  through. A tab pads with spaces and runs the restoring divider after each
//  space that may be followed by another.
//  Synchronous active-low reset restores the register defaults and the cursor
//  to the origin. Results go through a pending stage and an output register;
//  the sequencer holds when the output register is full and not being taken.
//  Configuration writes are always ready.
// ----------------------------------------------------------------------------
module text_cursor_terminal_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: char_code[7:0], new_x[17:8], new_y[27:18], zero[31:28]
    input  logic [tcte_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: operation[0]
    input  logic [0:0]                        s_axis_tuser,
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: cell_x[15:0], cell_y[31:16], glyph_index[39:32],
    //        scroll_lines[54:40], zero[55]
    output logic [tcte_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: command_kind[1:0]
    output logic [tcte_pkg::KIND_W-1:0]       m_axis_tuser,
    output logic                              m_axis_tlast,
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcte_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tcte_pkg::t_cmd  cmd;
    tcte_pkg::t_stat stat;

    logic                            in_ready;
    logic [tcte_pkg::CURSOR_W-1:0]   cell_x;
    logic [tcte_pkg::CURSOR_W-1:0]   cell_y;
    logic [tcte_pkg::CODE_W-1:0]     glyph_index;
    logic [tcte_pkg::SCROLL_W-1:0]   scroll_lines;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = in_ready;

    // Sequencer
    tcte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Cursor, configuration and result registers
    tcte_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_operation    (s_axis_tuser[0]),
        .i_char_code    (s_axis_tdata[7:0]),
        .i_new_x        (s_axis_tdata[17:8]),
        .i_new_y        (s_axis_tdata[27:18]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_kind         (m_axis_tuser),
        .o_cell_x       (cell_x),
        .o_cell_y       (cell_y),
        .o_glyph_index  (glyph_index),
        .o_scroll_lines (scroll_lines),
        .o_last         (m_axis_tlast)
    );

    // Pack result beat, lowest field first
    assign m_axis_tdata = {1'b0, scroll_lines, glyph_index, cell_y, cell_x};

endmodule

// ===== tb/tcte_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcte_checker
// Watches the input, output and configuration channels of the text cursor
// terminal engine, tracks cursor and font settings, predicts the command
// beats each accepted input beat causes and compares them in order.
// ----------------------------------------------------------------------------
module tcte_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream, as seen at the block
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // tdata: char_code[7:0], new_x[17:8], new_y[27:18], zero[31:28]
    input  logic [tcte_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: operation[0]
    input  logic [0:0]                        s_axis_tuser,
    // Output stream, as seen at the block
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: cell_x[15:0], cell_y[31:16], glyph_index[39:32],
    //        scroll_lines[54:40], zero[55]
    input  logic [tcte_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: command_kind[1:0]
    input  logic [tcte_pkg::KIND_W-1:0]       m_axis_tuser,
    input  logic                              m_axis_tlast,
    // Configuration writes
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [tcte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcte_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Status towards the stimulus side
    output int                                o_mismatches,
    output int                                o_outstanding,
    output int                                o_cmds_checked
);

    typedef struct packed {
        logic [tcte_pkg::KIND_W-1:0]   kind;
        logic [15:0]                   x;
        logic [15:0]                   y;
        logic [tcte_pkg::CODE_W-1:0]   glyph;
        logic [tcte_pkg::SCROLL_W-1:0] scroll;
        logic                          last;
    } t_term_cmd;

    // Cursor and font as the block should hold them
    int                          cur_x;
    int                          cur_y;
    logic [tcte_pkg::DIM_W-1:0]  font_w;
    logic [tcte_pkg::DIM_W-1:0]  font_h;
    logic [tcte_pkg::CODE_W-1:0] font_first;
    logic [tcte_pkg::CODE_W-1:0] font_count;
    logic                        font_transp;

    t_term_cmd item_cmds[$];
    t_term_cmd expected_cmds[$];
    int        errs;
    int        checked;

    // Keep the low 16 bits as a signed short
    function automatic int to_short(int v);
        logic signed [15:0] t;
        t = v[15:0];
        return int'(t);
    endfunction

    // Hold at most MAX_RESULTS commands per input beat, drop the rest
    function automatic void queue_cmd(logic [tcte_pkg::KIND_W-1:0] kind,
                                      int x, int y, int g, int s);
        t_term_cmd c;
        if (item_cmds.size() < tcte_pkg::MAX_RESULTS) begin
            c.kind   = kind;
            c.x      = x[15:0];
            c.y      = y[15:0];
            c.glyph  = g[tcte_pkg::CODE_W-1:0];
            c.scroll = s[tcte_pkg::SCROLL_W-1:0];
            c.last   = 1'b0;
            item_cmds.push_back(c);
        end
    endfunction

    function automatic bit font_has(int c);
        int f;
        int n;
        f = font_first;
        n = font_count;
        return (c >= f) && (c < f + n);
    endfunction

    // New line; clamp to the bottom row and scroll by the overshoot
    function automatic void feed_line();
        int h;
        int d;
        h = font_h;
        cur_x = 0;
        cur_y = to_short(cur_y + h);
        d = cur_y + h - tcte_pkg::SCREEN_HEIGHT;
        if (d >= 0) begin
            if (d > 0) queue_cmd(tcte_pkg::KIND_SCROLL, 0, 0, 0, d);
            cur_y = to_short(cur_y - d);
        end
    endfunction

    // Wrap to the next line before a font character that would not fit
    function automatic void wrap_before(int c);
        int w;
        w = font_w;
        if (font_has(c) && (cur_x + w > tcte_pkg::SCREEN_WIDTH)) begin
            cur_x = 0;
            feed_line();
        end
    endfunction

    function automatic void put_cell(int c);
        int w;
        int f;
        w = font_w;
        f = font_first;
        if (font_has(c))
            queue_cmd(tcte_pkg::KIND_DRAW, cur_x, cur_y, c - f, 0);
        else if (!font_transp)
            queue_cmd(tcte_pkg::KIND_FILL, cur_x, cur_y, 0, 0);
        cur_x = to_short(cur_x + w);
    endfunction

    function automatic void predict_char(logic [tcte_pkg::CODE_W-1:0] ch);
        int w;
        int h;
        int c;
        w = font_w;
        h = font_h;
        c = ch;
        wrap_before(c);
        case (ch)
            tcte_pkg::CH_BS: begin
                cur_x = to_short(cur_x - w);
                if (cur_x < 0) begin
                    cur_y = to_short(cur_y - h);
                    if (cur_y < 0) cur_y = 0;
                    cur_x = to_short(cur_x + tcte_pkg::SCREEN_WIDTH);
                end
            end
            tcte_pkg::CH_CR: begin
                cur_x = 0;
            end
            tcte_pkg::CH_LF: begin
                feed_line();
            end
            tcte_pkg::CH_TAB: begin
                // Pad with spaces until the cell column is even
                for (int i = 0; i < tcte_pkg::TAB_LIMIT; i++) begin
                    wrap_before(int'(tcte_pkg::CH_SPACE));
                    put_cell(int'(tcte_pkg::CH_SPACE));
                    if (w == 0) break;
                    if ((cur_x / w) % 2 == 0) break;
                end
            end
            default: begin
                put_cell(c);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (errs < 40)
            $display("[%0t ns] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        errs++;
    endtask

    task automatic check_cmd();
        t_term_cmd want;
        if (expected_cmds.size() == 0) begin
            report_mismatch("command beat with nothing expected", m_axis_tdata, 0);
        end else begin
            want = expected_cmds.pop_front();
            if (m_axis_tuser != want.kind)
                report_mismatch("command_kind", m_axis_tuser, want.kind);
            if (m_axis_tdata[15:0] != want.x)
                report_mismatch("cell_x", m_axis_tdata[15:0], want.x);
            if (m_axis_tdata[31:16] != want.y)
                report_mismatch("cell_y", m_axis_tdata[31:16], want.y);
            if (m_axis_tdata[39:32] != want.glyph)
                report_mismatch("glyph_index", m_axis_tdata[39:32], want.glyph);
            if (m_axis_tdata[54:40] != want.scroll)
                report_mismatch("scroll_lines", m_axis_tdata[54:40], want.scroll);
            if (m_axis_tdata[55] != 1'b0)
                report_mismatch("tdata pad bit", m_axis_tdata[55], 0);
            if (m_axis_tlast != want.last)
                report_mismatch("tlast", m_axis_tlast, want.last);
        end
        checked++;
    endtask

    // Compare output beats first: a beat leaving now belongs to an older input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_x       = 0;
            cur_y       = 0;
            font_w      = 7'd8;
            font_h      = 7'd8;
            font_first  = 8'd32;
            font_count  = 8'd95;
            font_transp = 1'b0;
            expected_cmds.delete();
            errs    = 0;
            checked = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_cmd();

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tcte_pkg::CFG_GLYPH_WIDTH:  font_w      = i_cfg_data[tcte_pkg::DIM_W-1:0];
                    tcte_pkg::CFG_GLYPH_HEIGHT: font_h      = i_cfg_data[tcte_pkg::DIM_W-1:0];
                    tcte_pkg::CFG_FIRST_CODE:   font_first  = i_cfg_data;
                    tcte_pkg::CFG_CODE_COUNT:   font_count  = i_cfg_data;
                    tcte_pkg::CFG_TRANSPARENT:  font_transp = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == tcte_pkg::OP_SET) begin
                    cur_x = s_axis_tdata[17:8];
                    cur_y = s_axis_tdata[27:18];
                end else begin
                    item_cmds.delete();
                    predict_char(s_axis_tdata[7:0]);
                    if (item_cmds.size() > 0) item_cmds[item_cmds.size()-1].last = 1'b1;
                    foreach (item_cmds[k]) expected_cmds.push_back(item_cmds[k]);
                end
            end
        end
        o_mismatches   <= errs;
        o_outstanding  <= expected_cmds.size();
        o_cmds_checked <= checked;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the text cursor terminal engine. Runs directed
// cursor and character cases under the default and extreme fonts, then random
// traffic under random fonts, with bursty input and a stalling receiver. The
// checker beside the block predicts and compares every command beat.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 120;
    localparam int RAND_PHASES   = 6;
    localparam int RAND_ITEMS    = 20;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [tcte_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [0:0]                        s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [tcte_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic [tcte_pkg::KIND_W-1:0]       m_axis_tuser;
    logic                              m_axis_tlast;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [tcte_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [tcte_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    int mismatches;
    int outstanding;
    int cmds_checked;

    int  cycles = 0;
    int  burst_left = 0;
    int  beats_sent = 0;
    int  fonts_used = 1;
    int  font_first = 32;
    int  font_count = 95;
    bit  no_idle = 1'b0;

    logic [15:0] stall_pat = 16'hFFFF;
    int          pat_age = 0;

    text_cursor_terminal_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tcte_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_cmds_checked (cmds_checked)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Stall the receiver on a rotating pattern, refreshed with a random one by an age counter
    always @(posedge i_clk) begin
        if (pat_age == 63) begin
            stall_pat <= 16'($urandom) | 16'h0001;
            pat_age   <= 0;
        end else begin
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
            pat_age   <= pat_age + 1;
        end
        m_axis_tready <= no_idle | stall_pat[0];
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d commands still expected",
                     cycles, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Send one beat; open a new burst after a random gap when the last one ran out
    task automatic send_beat(logic op, logic [7:0] ch, logic [9:0] nx, logic [9:0] ny);
        int gap;
        if (burst_left <= 0) begin
            gap = no_idle ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = no_idle ? 1000 : $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, ny, nx, ch};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        beats_sent++;
    endtask

    task automatic put_char(logic [7:0] ch);
        send_beat(tcte_pkg::OP_PUT, ch, 10'($urandom), 10'($urandom));
    endtask

    task automatic move_cursor(int x, int y);
        send_beat(tcte_pkg::OP_SET, 8'($urandom), x[9:0], y[9:0]);
    endtask

    // Hold input until every expected command is out and the block has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [tcte_pkg::CFG_IDX_W-1:0] idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[tcte_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write every font register back to back; call only when drained
    task automatic load_font(int w, int h, int first, int count, int transp);
        cfg_write(tcte_pkg::CFG_GLYPH_WIDTH, w);
        cfg_write(tcte_pkg::CFG_GLYPH_HEIGHT, h);
        cfg_write(tcte_pkg::CFG_FIRST_CODE, first);
        cfg_write(tcte_pkg::CFG_CODE_COUNT, count);
        cfg_write(tcte_pkg::CFG_TRANSPARENT, transp);
        i_cfg_valid <= 1'b0;
        font_first = first;
        font_count = count;
        fonts_used++;
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 3))
            0:       return 1;
            1:       return 64;
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    function automatic int pick_code_byte();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_pos();
        if ($urandom_range(0, 2) == 0) return $urandom_range(300, 330);
        return $urandom_range(0, 1023);
    endfunction

    // Mix of cursor moves, control codes and characters biased into the font
    task automatic random_beat();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            move_cursor(pick_pos(), pick_pos());
        end else if (r < 35) begin
            case ($urandom_range(0, 4))
                0:       put_char(tcte_pkg::CH_BS);
                1:       put_char(tcte_pkg::CH_CR);
                2:       put_char(tcte_pkg::CH_LF);
                default: put_char(tcte_pkg::CH_TAB);
            endcase
        end else if (r < 70 && font_count > 0) begin
            put_char(8'(font_first + $urandom_range(0, font_count - 1)));
        end else begin
            put_char(8'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default font: printable ends, codes outside the font, control codes
        put_char(tcte_pkg::CH_SPACE);
        put_char(8'h7E);
        put_char(8'h7F);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(tcte_pkg::CH_CR);
        move_cursor(0, 0);
        put_char(tcte_pkg::CH_BS);    // back off the top-left corner
        move_cursor(316, 0);
        put_char(8'h41);              // wraps before drawing
        move_cursor(0, 1023);
        put_char(tcte_pkg::CH_LF);    // large scroll
        move_cursor(0, 0);
        put_char(tcte_pkg::CH_TAB);   // two spaces to reach an even cell
        move_cursor(1023, 1023);
        put_char(8'h5A);              // wrap, scroll, then draw
        drain();

        // Widest cells, every code but 255 in the font, transparent fill
        load_font(64, 64, 0, 255, 1);
        move_cursor(300, 300);
        put_char(tcte_pkg::CH_BS);    // control code wraps first
        move_cursor(290, 1000);
        put_char(tcte_pkg::CH_TAB);   // wraps and scrolls, then pads two spaces
        put_char(8'hFF);              // outside the font, nothing drawn
        put_char(tcte_pkg::CH_LF);
        drain();

        // Zero-width cells: tab stops after one space
        load_font(0, 1, 255, 255, 0);
        put_char(tcte_pkg::CH_TAB);
        put_char(8'hFF);
        put_char(8'h41);
        drain();

        // Empty font
        load_font(1, 64, 0, 0, 1);
        put_char(tcte_pkg::CH_TAB);
        put_char(8'h20);
        drain();

        // Random fonts and traffic; one phase runs without any idling
        for (int p = 0; p < RAND_PHASES; p++) begin
            load_font(pick_dim(), pick_dim(), pick_code_byte(), pick_code_byte(),
                      $urandom_range(0, 1));
            no_idle = (p == 2);
            repeat (RAND_ITEMS) random_beat();
            drain();
            no_idle = 1'b0;
        end

        $display("Run covered %0d input beats under %0d font settings", beats_sent, fonts_used);
        $display("and compared %0d command beats against the prediction.", cmds_checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
